// ===== design/unpack_10bit_samples_defines.svh =====
// Assertion macros for the 10-bit sample unpacker.
`ifndef UNPACK_10BIT_SAMPLES_DEFINES_SVH
`define UNPACK_10BIT_SAMPLES_DEFINES_SVH
`ifndef SYNTHESIS
`define UPS_ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) \
        else $error(msg);
`define UPS_ASSERT_IMPLIES(label, pre, post, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error(msg);
`else
`define UPS_ASSERT_NEVER(label, cond, msg)
`define UPS_ASSERT_IMPLIES(label, pre, post, msg)
`endif
`endif

// ===== design/ups_pkg.sv =====
// Types, constants and the block reshuffle function of the sample unpacker.
`timescale 1ns / 1ps
`default_nettype none
package ups_pkg;

    localparam int WORD_BITS   = 32;
    localparam int SAMPLE_BITS = 10;
    localparam int LEFT_BITS   = 9;
    localparam int ACC_BITS    = LEFT_BITS + WORD_BITS;
    localparam int BLK_WORDS   = 10;
    localparam int BLK_BYTES   = 40;
    localparam int BLK_BITS    = BLK_BYTES * 8;
    localparam int CMD_DEPTH   = 4;
    localparam int CMD_PTR_W   = 2;

    // Source byte of each reshuffled byte: 8-byte pieces reversed, then 10-byte pieces.
    localparam logic [5:0] SRC_BYTE [BLK_BYTES] = '{
        6'd14, 6'd15, 6'd0,  6'd1,  6'd2,  6'd3,  6'd4,  6'd5,  6'd6,  6'd7,
        6'd20, 6'd21, 6'd22, 6'd23, 6'd8,  6'd9,  6'd10, 6'd11, 6'd12, 6'd13,
        6'd26, 6'd27, 6'd28, 6'd29, 6'd30, 6'd31, 6'd16, 6'd17, 6'd18, 6'd19,
        6'd32, 6'd33, 6'd34, 6'd35, 6'd36, 6'd37, 6'd38, 6'd39, 6'd24, 6'd25
    };

    typedef struct packed {
        logic [31:0] payload_word;
        logic        heap_end;
    } t_in;

    typedef struct packed {
        logic signed [9:0] sample;
        logic              last_of_run;
        logic              heap_done;
    } t_out;

    typedef struct packed {
        logic [WORD_BITS-1:0] word;
        logic                 clear_only;
        logic                 run_end;
        logic                 hend;
    } t_cmd;

    // Byte 0 of a block sits in the top byte of the vector.
    function automatic logic [BLK_BITS-1:0] reshuffle_block(input logic [BLK_BITS-1:0] raw);
        logic [BLK_BITS-1:0] res;
        res = '0;
        for (int f = 0; f < BLK_BYTES; f++) begin
            res[BLK_BITS-1-8*f -: 8] = raw[BLK_BITS-1-8*int'(SRC_BYTE[f]) -: 8];
        end
        return res;
    endfunction

endpackage
`default_nettype wire

// ===== design/ups_front.sv =====
// Front end: takes input beats, gathers reshuffle blocks and issues unpack commands.
`timescale 1ns / 1ps
`default_nettype none
module ups_front (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_cfg_we,
    input  wire logic         i_cfg_wdata,
    input  wire logic         push,
    output logic              full,
    input  wire ups_pkg::t_in i_in,
    output logic              o_cmd_push,
    output ups_pkg::t_cmd     o_cmd,
    input  wire logic         i_cmd_full
);
    import ups_pkg::*;

    logic                r_mode;
    logic [BLK_BITS-1:0] r_blk,  n_blk;
    logic [3:0]          r_idx,  n_idx;
    logic [3:0]          r_unl,  n_unl;
    logic                r_unl_hend, n_unl_hend;
    logic                unloading;
    logic                accept;
    logic [BLK_BITS-1:0] shifted;

    assign unloading = (r_unl != 4'd0);
    assign full      = unloading | i_cmd_full;
    assign accept    = push & ~full;
    assign shifted   = {r_blk[BLK_BITS-WORD_BITS-1:0], i_in.payload_word};

    always_comb begin
        n_blk      = r_blk;
        n_idx      = r_idx;
        n_unl      = r_unl;
        n_unl_hend = r_unl_hend;
        o_cmd_push = 1'b0;
        o_cmd      = '{word: i_in.payload_word, clear_only: 1'b0, run_end: 1'b1,
                       hend: i_in.heap_end};
        if (unloading) begin
            if (!i_cmd_full) begin
                o_cmd_push = 1'b1;
                o_cmd      = '{word: r_blk[BLK_BITS-1 -: WORD_BITS], clear_only: 1'b0,
                               run_end: (r_unl == 4'd1),
                               hend: (r_unl == 4'd1) & r_unl_hend};
                n_blk      = {r_blk[BLK_BITS-WORD_BITS-1:0], {WORD_BITS{1'b0}}};
                n_unl      = r_unl - 4'd1;
            end
        end else if (accept) begin
            if (r_mode) begin
                if (r_idx == 4'(BLK_WORDS - 1)) begin
                    n_blk      = reshuffle_block(shifted);
                    n_idx      = 4'd0;
                    n_unl      = 4'(BLK_WORDS);
                    n_unl_hend = i_in.heap_end;
                end else begin
                    n_blk = shifted;
                    if (i_in.heap_end) begin
                        // partial block dropped, leftover bits still cleared
                        n_idx      = 4'd0;
                        o_cmd_push = 1'b1;
                        o_cmd.clear_only = 1'b1;
                    end else begin
                        n_idx = r_idx + 4'd1;
                    end
                end
            end else begin
                o_cmd_push = 1'b1;
                if (i_in.heap_end) begin
                    n_idx = 4'd0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_blk      <= n_blk;
        r_unl_hend <= n_unl_hend;
        if (!i_rst_n) begin
            r_mode <= 1'b0;
            r_idx  <= 4'd0;
            r_unl  <= 4'd0;
        end else begin
            if (i_cfg_we) begin
                r_mode <= i_cfg_wdata;
            end
            r_idx <= n_idx;
            r_unl <= n_unl;
        end
    end

endmodule
`default_nettype wire

// ===== design/ups_cmd_q.sv =====
// Short command queue between the front end and the unpacker.
`timescale 1ns / 1ps
`default_nettype none
module ups_cmd_q (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire ups_pkg::t_cmd i_cmd,
    output logic               o_full,
    input  wire logic          i_pop,
    output ups_pkg::t_cmd      o_cmd,
    output logic               o_empty
);
    import ups_pkg::*;

    t_cmd                 r_mem [CMD_DEPTH];
    logic [CMD_PTR_W-1:0] r_wptr;
    logic [CMD_PTR_W-1:0] r_rptr;
    logic [CMD_PTR_W:0]   r_cnt;
    logic                 do_push;
    logic                 do_pop;

    assign o_full  = (r_cnt == (CMD_PTR_W+1)'(CMD_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign do_push = i_push & ~o_full;
    assign do_pop  = i_pop & ~o_empty;
    assign o_cmd   = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_cmd;
        end
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (do_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule
`default_nettype wire

// ===== design/ups_back.sv =====
// Back end: cuts each command word, with the leftover bits, into 10-bit samples.
`timescale 1ns / 1ps
`default_nettype none
module ups_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire ups_pkg::t_cmd i_cmd,
    input  wire logic          i_cmd_empty,
    output logic               o_cmd_pop,
    output logic               empty,
    input  wire logic          pop,
    output ups_pkg::t_out      o_out,
    output logic [3:0]         o_left_cnt
);
    import ups_pkg::*;

    logic                 r_busy,      n_busy;
    logic [ACC_BITS-1:0]  r_acc,       n_acc;
    logic [5:0]           r_rem,       n_rem;
    logic                 r_run_end,   n_run_end;
    logic                 r_hend,      n_hend;
    logic [LEFT_BITS-1:0] r_left_bits, n_left_bits;
    logic [3:0]           r_left_cnt,  n_left_cnt;
    t_out                 r_out,       n_out;
    logic                 r_out_valid, n_out_valid;

    logic                 emit;
    logic                 done;
    logic [5:0]           rem_dec;
    logic [ACC_BITS-1:0]  acc_shift;
    logic [ACC_BITS-1:0]  acc_load;

    assign o_cmd_pop  = ~r_busy & ~i_cmd_empty;
    assign emit       = r_busy & (~r_out_valid | pop);
    assign rem_dec    = r_rem - 6'd10;
    assign done       = emit & (rem_dec < 6'd10);
    assign acc_shift  = {r_acc[ACC_BITS-SAMPLE_BITS-1:0], {SAMPLE_BITS{1'b0}}};
    // stream left-aligned in the accumulator, zeros below
    assign acc_load   = ACC_BITS'({r_left_bits, i_cmd.word} << (4'd9 - r_left_cnt));
    assign empty      = ~r_out_valid;
    assign o_out      = r_out;
    assign o_left_cnt = r_left_cnt;

    always_comb begin
        n_busy      = r_busy;
        n_acc       = r_acc;
        n_rem       = r_rem;
        n_run_end   = r_run_end;
        n_hend      = r_hend;
        n_left_bits = r_left_bits;
        n_left_cnt  = r_left_cnt;
        n_out       = r_out;
        n_out_valid = r_out_valid & ~pop;
        if (o_cmd_pop) begin
            if (i_cmd.clear_only) begin
                n_left_bits = '0;
                n_left_cnt  = 4'd0;
            end else begin
                n_busy    = 1'b1;
                n_acc     = acc_load;
                n_rem     = 6'(r_left_cnt) + 6'(WORD_BITS);
                n_run_end = i_cmd.run_end;
                n_hend    = i_cmd.hend;
            end
        end
        if (emit) begin
            n_acc       = acc_shift;
            n_rem       = rem_dec;
            n_out_valid = 1'b1;
            n_out       = '{sample: r_acc[ACC_BITS-1 -: SAMPLE_BITS],
                            last_of_run: done & r_run_end,
                            heap_done: done & r_run_end & r_hend};
            if (done) begin
                n_busy = 1'b0;
                if (r_hend) begin
                    n_left_bits = '0;
                    n_left_cnt  = 4'd0;
                end else begin
                    n_left_bits = acc_shift[ACC_BITS-1 -: LEFT_BITS] >> (4'd9 - rem_dec[3:0]);
                    n_left_cnt  = rem_dec[3:0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc     <= n_acc;
        r_rem     <= n_rem;
        r_run_end <= n_run_end;
        r_hend    <= n_hend;
        r_out     <= n_out;
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_left_bits <= '0;
            r_left_cnt  <= 4'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_busy      <= n_busy;
            r_left_bits <= n_left_bits;
            r_left_cnt  <= n_left_cnt;
            r_out_valid <= n_out_valid;
        end
    end

endmodule
`default_nettype wire

// ===== design/unpack_10bit_samples.sv =====
// Top level of the packed 10-bit signed sample unpacker.
`timescale 1ns / 1ps
`default_nettype none
// Takes 32-bit payload beats (first byte in bits 31..24) and delivers 10-bit
// two's-complement samples, one per cycle at most, through a queue-style
// result port. In normal mode each word is first loaded into the unpacker
// and then cut into 3 or 4 samples. With reshuffle_mode set, ten words are
// taken one per cycle while full is low; the tenth turns the block around as
// it is taken, full then stays high while the block's words move into the
// four-deep command queue, and the unpacker cuts the block into 32 samples.
// heap_end clears the leftover bits and any partial block; a partial block is
// dropped without results. Write reshuffle_mode only while the block is idle.
module unpack_10bit_samples (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_cfg_we,
    input  wire logic         i_cfg_wdata,
    input  wire logic         push,
    output logic              full,
    input  wire ups_pkg::t_in i_in,
    output logic              empty,
    input  wire logic         pop,
    output ups_pkg::t_out     o_out
);
    import ups_pkg::*;

    `include "unpack_10bit_samples_defines.svh"

    t_cmd       cmd_in;
    t_cmd       cmd_out;
    logic       cmd_push;
    logic       cmd_full;
    logic       cmd_pop;
    logic       cmd_empty;
    logic [3:0] left_cnt;

    ups_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .push        (push),
        .full        (full),
        .i_in        (i_in),
        .o_cmd_push  (cmd_push),
        .o_cmd       (cmd_in),
        .i_cmd_full  (cmd_full)
    );

    ups_cmd_q u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_push),
        .i_cmd   (cmd_in),
        .o_full  (cmd_full),
        .i_pop   (cmd_pop),
        .o_cmd   (cmd_out),
        .o_empty (cmd_empty)
    );

    ups_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd_out),
        .i_cmd_empty (cmd_empty),
        .o_cmd_pop   (cmd_pop),
        .empty       (empty),
        .pop         (pop),
        .o_out       (o_out),
        .o_left_cnt  (left_cnt)
    );

    `UPS_ASSERT_NEVER(a_cmd_overflow, cmd_push && cmd_full, "command pushed into full queue")
    `UPS_ASSERT_NEVER(a_left_range, left_cnt > 4'd9, "leftover count above nine")
    `UPS_ASSERT_IMPLIES(a_done_is_last, !empty && o_out.heap_done, o_out.last_of_run,
        "heap_done without last_of_run")
    `UPS_ASSERT_IMPLIES(a_full_on_push, cmd_push && !cmd_pop && cmd_empty, ##1 !cmd_empty,
        "queued command lost")

endmodule
`default_nettype wire

// ===== test/unpack_10bit_samples_test.sv =====
// Self-checking testbench for the packed 10-bit signed sample unpacker.
`timescale 1ns / 1ps
module unpack_10bit_samples_test;
    import ups_pkg::*;

    localparam int BLOCK_WORDS   = 10;
    localparam int BLOCK_BYTES   = 40;
    localparam int SETTLE_CYCLES = 80;
    localparam int HOLD_CYCLES   = 300;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int RAND_PHASES   = 6;
    localparam int PHASE_ITEMS   = 74;
    localparam int MAX_LINES     = 40;

    typedef enum int {POP_ALWAYS, POP_PATTERN, POP_MOSTLY, POP_RARELY} pop_style_e;

    class sample_tracker;
        bit         mode;
        bit [8:0]   carry_bits;
        bit [3:0]   carry_cnt;
        bit [31:0]  blk [BLOCK_WORDS];
        int         blk_fill;
        t_out       fresh [$];
        t_out       due [$];
        int         errors;

        function int pending();
            return due.size();
        endfunction

        function void unpack_word(logic [31:0] w);
            logic [40:0] acc;
            int          bits;
            t_out        s;
            acc = {carry_bits, w};
            bits = int'(carry_cnt) + 32;
            while (bits >= 10) begin
                bits -= 10;
                s.sample = acc[bits +: 10];
                s.last_of_run = 1'b0;
                s.heap_done = 1'b0;
                fresh.insert(fresh.size(), s);
            end
            carry_bits = 9'(acc & ((41'd1 << bits) - 41'd1));
            carry_cnt = 4'(bits);
        endfunction

        function void unpack_block();
            logic [7:0] raw [BLOCK_BYTES];
            logic [7:0] mid [BLOCK_BYTES];
            logic [7:0] fix [BLOCK_BYTES];
            for (int k = 0; k < BLOCK_BYTES; k++)
                raw[k] = 8'(blk[k / 4] >> (24 - 8 * (k % 4)));
            for (int k = 0; k < BLOCK_BYTES; k++)
                mid[k] = raw[(4 - k / 8) * 8 + k % 8];
            for (int k = 0; k < BLOCK_BYTES; k++)
                fix[k] = mid[(3 - k / 10) * 10 + k % 10];
            for (int k = 0; k < BLOCK_WORDS; k++)
                unpack_word({fix[4 * k], fix[4 * k + 1], fix[4 * k + 2], fix[4 * k + 3]});
        endfunction

        function void take_word(t_in item);
            int last;
            fresh.delete();
            if (mode) begin
                if (blk_fill >= BLOCK_WORDS) blk_fill = 0;
                blk[blk_fill] = item.payload_word;
                blk_fill++;
                if (blk_fill == BLOCK_WORDS) begin
                    blk_fill = 0;
                    unpack_block();
                end
            end else begin
                unpack_word(item.payload_word);
            end
            last = fresh.size() - 1;
            if (last >= 0) begin
                fresh[last].last_of_run = 1'b1;
                fresh[last].heap_done = item.heap_end;
            end
            if (item.heap_end) begin
                carry_bits = '0;
                carry_cnt = '0;
                blk_fill = 0;
            end
            foreach (fresh[i]) due.insert(due.size(), fresh[i]);
        endfunction

        task report(string what);
            if (errors < MAX_LINES) $display("MISMATCH at %0t: %s", $time, what);
            errors++;
        endtask

        task check_sample(t_out got);
            t_out want;
            if (due.size() == 0) begin
                report($sformatf("sample %0d with none due", got.sample));
                return;
            end
            want = due[0];
            due.delete(0);
            if (got.sample !== want.sample)
                report($sformatf("sample got %0d want %0d", got.sample, want.sample));
            if (got.last_of_run !== want.last_of_run)
                report($sformatf("last_of_run got %b want %b", got.last_of_run,
                                 want.last_of_run));
            if (got.heap_done !== want.heap_done)
                report($sformatf("heap_done got %b want %b", got.heap_done, want.heap_done));
        endtask
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_cfg_we;
    logic i_cfg_wdata;
    logic push;
    logic full;
    t_in  i_in;
    logic empty;
    logic pop;
    t_out o_out;

    sample_tracker tracker = new();
    bit            hold_pending;
    int            burst_left;
    int            cycles;

    unpack_10bit_samples dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .push        (push),
        .full        (full),
        .i_in        (i_in),
        .empty       (empty),
        .pop         (pop),
        .o_out       (o_out)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    function automatic logic [31:0] pick_word();
        int unsigned roll;
        roll = $urandom_range(0, 9);
        if (roll == 0) return 32'h0000_0000;
        if (roll == 1) return 32'hFFFF_FFFF;
        return $urandom;
    endfunction

    task automatic send_word(input t_in item);
        if (burst_left == 0) begin
            push <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 8);
        end
        push <= 1'b1;
        i_in <= item;
        forever begin
            @(posedge i_clk);
            if (!full) break;
        end
        tracker.take_word(item);
        burst_left--;
    endtask

    task automatic drain();
        push <= 1'b0;
        while (tracker.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_mode(input logic m);
        drain();
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= m;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        tracker.mode = m;
        burst_left = 0;
    endtask

    initial begin : result_side
        pop_style_e  style;
        int          span;
        int          hold_left;
        logic [15:0] pattern;
        logic        nxt;
        pop <= 1'b0;
        style = POP_ALWAYS;
        span = 0;
        hold_left = 0;
        pattern = 16'hFFFF;
        forever begin
            @(posedge i_clk);
            if (pop && !empty) tracker.check_sample(o_out);
            if (span == 0) begin
                span = $urandom_range(20, 120);
                style = pop_style_e'($urandom_range(0, 3));
                pattern = 16'($urandom);
            end
            span--;
            pattern = {pattern[14:0], pattern[15]};
            case (style)
                POP_ALWAYS: nxt = 1'b1;
                POP_PATTERN: nxt = pattern[0];
                POP_MOSTLY: nxt = ($urandom_range(0, 3) != 0);
                default: nxt = ($urandom_range(0, 7) == 0);
            endcase
            if (hold_pending) begin
                hold_pending = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left != 0) begin
                hold_left--;
                nxt = 1'b0;
            end
            if (!i_rst_n) nxt = 1'b0;
            pop <= nxt;
        end
    end

    initial begin : word_side
        t_in item;
        cycles <= 0;
        i_rst_n <= 1'b0;
        i_cfg_we <= 1'b0;
        i_cfg_wdata <= 1'b0;
        push <= 1'b0;
        i_in <= '0;
        burst_left = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // normal mode: sample extremes, leftover count walks 2,4,6,8,0
        set_mode(1'b0);
        item = '{payload_word: 32'h8020_0800, heap_end: 1'b1};
        send_word(item);
        item = '{payload_word: 32'h7FDF_F7FF, heap_end: 1'b0};
        send_word(item);
        item = '{payload_word: 32'h0000_0000, heap_end: 1'b0};
        send_word(item);
        item = '{payload_word: 32'hFFFF_FFFF, heap_end: 1'b0};
        send_word(item);
        item = '{payload_word: 32'hAAAA_AAAA, heap_end: 1'b0};
        send_word(item);
        item = '{payload_word: 32'h5555_5555, heap_end: 1'b0};
        send_word(item);
        item = '{payload_word: $urandom, heap_end: 1'b0};
        send_word(item);
        item = '{payload_word: 32'h1234_5678, heap_end: 1'b1};
        send_word(item);

        // reshuffle: one full block ending a heap, then a partial block dropped at heap end
        set_mode(1'b1);
        for (int w = 0; w < BLOCK_WORDS; w++) begin
            item.payload_word = {8'(4 * w), 8'(4 * w + 1), 8'(4 * w + 2), 8'(4 * w + 3)};
            item.heap_end = (w == BLOCK_WORDS - 1);
            send_word(item);
        end
        item = '{payload_word: 32'hDEAD_BEEF, heap_end: 1'b0};
        send_word(item);
        item = '{payload_word: 32'hFFFF_FFFF, heap_end: 1'b1};
        send_word(item);

        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            set_mode(ph % 2 == 0);
            if (ph == 1) hold_pending = 1'b1;
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                item.payload_word = pick_word();
                if (tracker.mode)
                    item.heap_end = (tracker.blk_fill == BLOCK_WORDS - 1 &&
                                     $urandom_range(0, 3) == 0) ||
                                    $urandom_range(0, 39) == 0;
                else
                    item.heap_end = ($urandom_range(0, 11) == 0);
                send_word(item);
            end
        end

        drain();
        if (tracker.errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end
endmodule
